/* src/page_range_hole_allocator_core_macros.svh */
`ifndef PAGE_RANGE_HOLE_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_RANGE_HOLE_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRHA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prha check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prha check failed");

`endif

/* src/prha_pkg.sv */
`default_nettype none
package prha_pkg;

	localparam int PAGE_W  = 36;
	localparam int COUNT_W = 20;
	localparam logic [PAGE_W-1:0] PAGE_MASK = {PAGE_W{1'b1}};
	localparam logic [PAGE_W-1:0] LIMIT_RESET = 36'd1048576;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_OUTSIDE   = 2'd2,
		ST_LEAKED    = 2'd3
	} status_t;

	typedef enum logic {
		CFG_HEAP_FIRST = 1'b0,
		CFG_HEAP_LIMIT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic               opcode;
		logic [COUNT_W-1:0] page_count;
		logic [PAGE_W-1:0]  release_page;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] granted_page;
		logic              from_hole;
	} out_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] length;
	} hole_t;

endpackage
`default_nettype wire

/* src/page_range_hole_allocator_core.sv */
`default_nettype none
// First-fit allocator of page ranges with coalescing of released ranges. The hole table
// lives in a synchronous RAM that is read one slot per cycle; valid bits are flip-flops.
// An allocate takes one pass over the table. A release takes one pass per merge plus a
// final pass, each restart beginning at slot zero. A release outside the heap window skips
// the scan. The single RAM read port sets the scan rate of one slot per cycle.
// One item is worked on at a time; a finished result waits in the output register.
`include "page_range_hole_allocator_core_macros.svh"
module page_range_hole_allocator_core
	import prha_pkg::*;
#(
	parameter int HOLE_SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_item,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [35:0] cfg_data
);

	localparam int IW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
	localparam int CW = $clog2(HOLE_SLOTS + 1);
	localparam int TW = PAGE_W + 1 + $clog2(HOLE_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_STORE = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	logic [PAGE_W-1:0] first_q, limit_q, bump_q;
	logic [PAGE_W:0] cursor_q;
	logic op_q;
	logic [COUNT_W-1:0] count_q;
	logic [PAGE_W-1:0] start_q;
	logic [TW-1:0] end_q;
	logic [CW-1:0] issue_q;
	logic eval_s1;
	logic [IW-1:0] idx_s1;
	logic free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [HOLE_SLOTS-1:0] valid_q;
	out_item_t res_q, out_q;
	logic out_valid_q;

	logic ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	hole_t ram_wdata, hole;

	logic hv, fit, exact, hit_a, hit_b, last, outside, out_free, merge;
	logic [PAGE_W:0] hole_end;
	logic [PAGE_W-1:0] clip_len;

	prha_hole_ram #(.DEPTH(HOLE_SLOTS), .AW(IW)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(hole)
	);

	always_comb begin
		hv       = valid_q[idx_s1];
		fit      = hv && (hole.length >= {{(PAGE_W-COUNT_W){1'b0}}, count_q});
		exact    = hole.length == {{(PAGE_W-COUNT_W){1'b0}}, count_q};
		hole_end = {1'b0, hole.base} + {1'b0, hole.length};
		hit_a    = hv && (hole_end == {1'b0, start_q});
		hit_b    = hv && (end_q == TW'(hole.base));
		merge    = eval_s1 && (op_q == OP_RELEASE) && (hit_a || hit_b);
		last     = eval_s1 && (idx_s1 == IW'(HOLE_SLOTS - 1));
		outside  = (in_item.release_page < first_q) || (in_item.release_page >= limit_q);
		out_free = !out_valid_q || !out_stall;
		if (end_q > TW'(PAGE_MASK)) begin
			clip_len = PAGE_MASK - start_q;
		end else begin
			clip_len = end_q[PAGE_W-1:0] - start_q;
		end

		ram_re    = (state_q == S_SCAN) && (issue_q < CW'(HOLE_SLOTS));
		ram_raddr = issue_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata.base   = hole.base + PAGE_W'(count_q);
		ram_wdata.length = hole.length - PAGE_W'(count_q);
		if (state_q == S_SCAN && eval_s1 && op_q == OP_ALLOC && fit && !exact) begin
			ram_we = 1'b1;
		end else if (state_q == S_STORE && free_found_q) begin
			ram_we           = 1'b1;
			ram_waddr        = free_idx_q;
			ram_wdata.base   = start_q;
			ram_wdata.length = clip_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_q      <= '0;
			limit_q      <= LIMIT_RESET;
			bump_q       <= '0;
			valid_q      <= '0;
			eval_s1      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_FIRST: first_q <= cfg_data;
					CFG_HEAP_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= in_item.opcode;
						count_q      <= in_item.page_count;
						start_q      <= in_item.release_page;
						end_q        <= TW'(in_item.release_page) + TW'(in_item.page_count);
						cursor_q     <= {1'b0, first_q} + {1'b0, bump_q};
						issue_q      <= '0;
						eval_s1      <= 1'b0;
						free_found_q <= 1'b0;
						if (in_item.opcode == OP_RELEASE && outside) begin
							res_q   <= '{status: ST_OUTSIDE, granted_page: '0, from_hole: 1'b0};
							state_q <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					idx_s1 <= ram_raddr;
					if (merge) begin
						issue_q      <= '0;
						eval_s1      <= 1'b0;
						free_found_q <= 1'b0;
					end else begin
						eval_s1 <= ram_re;
						if (ram_re) begin
							issue_q <= issue_q + CW'(1);
						end
					end
					if (eval_s1) begin
						if (op_q == OP_ALLOC) begin
							if (fit) begin
								res_q <= '{status: ST_OK, granted_page: hole.base, from_hole: 1'b1};
								if (exact) begin
									valid_q[idx_s1] <= 1'b0;
								end
								state_q <= S_OUT;
							end else if (last) begin
								if ({1'b0, cursor_q} + (PAGE_W+2)'(count_q) >
										(PAGE_W+2)'(limit_q)) begin
									res_q <= '{status: ST_EXHAUSTED, granted_page: '0,
										from_hole: 1'b0};
								end else begin
									res_q <= '{status: ST_OK, granted_page: cursor_q[PAGE_W-1:0],
										from_hole: 1'b0};
									bump_q <= bump_q + PAGE_W'(count_q);
								end
								state_q <= S_OUT;
							end
						end else begin
							if (hit_a || hit_b) begin
								valid_q[idx_s1] <= 1'b0;
								if (hit_a) begin
									start_q <= hole.base;
								end else begin
									end_q <= end_q + TW'(hole.length);
								end
							end else begin
								if (!hv && !free_found_q) begin
									free_found_q <= 1'b1;
									free_idx_q   <= idx_s1;
								end
								if (last) begin
									state_q <= S_STORE;
								end
							end
						end
					end
				end
				S_STORE: begin
					if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
						res_q <= '{status: ST_OK, granted_page: '0, from_hole: 1'b0};
					end else begin
						res_q <= '{status: ST_LEAKED, granted_page: '0, from_hole: 1'b0};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PRHA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && !in_stall,
		state_q == S_SCAN || state_q == S_OUT)
	`PRHA_ASSERT_SAME(a_eval_follows_read, clk, arst_n, eval_s1 && state_q == S_SCAN,
		$past(ram_re))
	`PRHA_ASSERT_SAME(a_write_in_work, clk, arst_n, ram_we,
		(state_q == S_SCAN && op_q == OP_ALLOC) || state_q == S_STORE)
	`PRHA_ASSERT_NEXT(a_out_loaded, clk, arst_n, state_q == S_OUT && out_free,
		out_valid_q && state_q == S_IDLE)

endmodule
`default_nettype wire

/* src/prha_hole_ram.sv */
`default_nettype none
module prha_hole_ram
	import prha_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire hole_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output hole_t              rdata
);

	hole_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* bench/tb_page_range_hole_allocator_core.sv */
`default_nettype none
module tb_page_range_hole_allocator_core;
	import prha_pkg::*;

	localparam int SLOTS = 64;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_we;
	logic        cfg_index;
	logic [35:0] cfg_data;

	page_range_hole_allocator_core #(.HOLE_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Allocator state as the bench predicts it.
	logic [PAGE_W-1:0] heap_first;
	logic [PAGE_W-1:0] heap_limit;
	logic [PAGE_W-1:0] hole_base_m [SLOTS];
	logic [PAGE_W-1:0] hole_len_m [SLOTS];
	logic              hole_used_m [SLOTS];
	logic [PAGE_W-1:0] bump_m;

	out_item_t pending_results[$];
	logic [PAGE_W-1:0] grant_page_q[$];
	logic [COUNT_W-1:0] grant_count_q[$];
	int  failures;
	bit  send_idle;
	bit  recv_idle;
	int  hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic out_item_t predict_item(in_item_t it);
		out_item_t r;
		longint unsigned cnt, start, total, cursor, hs, he;
		int i;
		bit found;
		r = '0;
		cnt = it.page_count;
		if (it.opcode == OP_ALLOC) begin
			found = 0;
			for (i = 0; i < SLOTS && !found; i++) begin
				if (hole_used_m[i] && hole_len_m[i] >= cnt) begin
					found = 1;
					r.granted_page = hole_base_m[i];
					r.from_hole = 1'b1;
					r.status = ST_OK;
					if (hole_len_m[i] == cnt)
						hole_used_m[i] = 1'b0;
					else begin
						hole_base_m[i] = PAGE_W'(hole_base_m[i] + cnt);
						hole_len_m[i] = PAGE_W'(hole_len_m[i] - cnt);
					end
				end
			end
			if (!found) begin
				cursor = longint'(heap_first) + longint'(bump_m);
				if (cursor + cnt > heap_limit)
					r.status = ST_EXHAUSTED;
				else begin
					r.status = ST_OK;
					r.granted_page = cursor[PAGE_W-1:0];
					bump_m = PAGE_W'(bump_m + cnt);
				end
			end
		end else begin
			start = it.release_page;
			total = cnt;
			if (start < heap_first || start >= heap_limit) begin
				r.status = ST_OUTSIDE;
				return r;
			end
			i = 0;
			while (i < SLOTS) begin
				if (hole_used_m[i]) begin
					hs = hole_base_m[i];
					he = hs + hole_len_m[i];
					if (he == start) begin
						start = hs;
						total += hole_len_m[i];
						hole_used_m[i] = 1'b0;
						i = 0;
						continue;
					end
					if (start + total == hs) begin
						total += hole_len_m[i];
						hole_used_m[i] = 1'b0;
						i = 0;
						continue;
					end
				end
				i++;
			end
			if (start + total > longint'(PAGE_MASK))
				total = longint'(PAGE_MASK) - start;
			r.status = ST_LEAKED;
			found = 0;
			for (i = 0; i < SLOTS && !found; i++) begin
				if (!hole_used_m[i]) begin
					found = 1;
					hole_base_m[i] = start[PAGE_W-1:0];
					hole_len_m[i] = total[PAGE_W-1:0];
					hole_used_m[i] = 1'b1;
					r.status = ST_OK;
				end
			end
		end
		return r;
	endfunction

	task automatic send_item(input in_item_t it, output out_item_t res);
		int gap;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		res = predict_item(it);
		do @(posedge clk); while (in_stall);
		pending_results.push_back(res);
	endtask

	task automatic do_alloc(input int cnt);
		in_item_t it;
		out_item_t res;
		it = '0;
		it.opcode = OP_ALLOC;
		it.page_count = COUNT_W'(cnt);
		it.release_page = PAGE_W'({$urandom, $urandom});
		send_item(it, res);
		if (res.status == ST_OK && cnt > 0) begin
			grant_page_q.push_back(res.granted_page);
			grant_count_q.push_back(COUNT_W'(cnt));
		end
	endtask

	task automatic do_release(input logic [PAGE_W-1:0] pg, input int cnt);
		in_item_t it;
		out_item_t res;
		it.opcode = OP_RELEASE;
		it.page_count = COUNT_W'(cnt);
		it.release_page = pg;
		send_item(it, res);
	endtask

	task automatic release_random_grant();
		int k;
		k = $urandom_range(0, grant_page_q.size() - 1);
		do_release(grant_page_q[k], grant_count_q[k]);
		grant_page_q.delete(k);
		grant_count_q.delete(k);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_index_t idx, input logic [PAGE_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_FIRST)
			heap_first = val;
		else
			heap_limit = val;
	endtask

	task automatic set_window(input logic [PAGE_W-1:0] lo, input logic [PAGE_W-1:0] hi);
		wait_drained();
		write_cfg(CFG_HEAP_FIRST, lo);
		write_cfg(CFG_HEAP_LIMIT, hi);
		grant_page_q.delete();
		grant_count_q.delete();
	endtask

	// Result checker.
	initial begin
		out_item_t exp_r;
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end else
				gap = recv_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				failures++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_item.status !== exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, out_item.status);
					failures++;
				end
				if (out_item.granted_page !== exp_r.granted_page) begin
					$error("granted_page expected %0h actual %0h",
						exp_r.granted_page, out_item.granted_page);
					failures++;
				end
				if (out_item.from_hole !== exp_r.from_hole) begin
					$error("from_hole expected %0d actual %0d",
						exp_r.from_hole, out_item.from_hole);
					failures++;
				end
			end
		end
	end

	task automatic test_directed();
		send_idle = 0;
		recv_idle = 0;
		do_alloc(0);
		do_alloc(1048575);
		do_alloc(1);
		do_alloc(1);
		do_release(LIMIT_RESET, 4);
		do_release(36'd0, 5);
		do_release(36'd5, 3);
		do_release(36'd20, 2);
		do_release(36'd8, 12);
		do_alloc(22);
		do_release(36'd100, 0);
		do_alloc(0);
		do_release(36'd200, 10);
		do_alloc(4);
		do_alloc(6);
		set_window(36'd0, PAGE_MASK);
		do_release(PAGE_MASK - 1, 1048575);
		do_release(PAGE_MASK, 1);
		do_alloc(1);
		set_window(PAGE_MASK, 36'd0);
		do_alloc(0);
		do_alloc(1);
		do_release(36'd0, 1);
		do_release(PAGE_MASK, 1);
	endtask

	task automatic test_churn(input int n);
		int r;
		send_idle = 1;
		recv_idle = 1;
		set_window(36'h0_0010_0000, 36'h0_0010_3000);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				do_alloc($urandom_range(0, 9) == 0 ? $urandom_range(64, 2048)
					: $urandom_range(1, 64));
			else if (r < 88 && grant_page_q.size() > 0)
				release_random_grant();
			else if (r < 94)
				do_release(heap_first + PAGE_W'($urandom_range(0, 36'h3000)),
					$urandom_range(1, 32));
			else
				do_release(PAGE_W'({$urandom, $urandom}), $urandom);
		end
	endtask

	task automatic test_table_full();
		int i;
		send_idle = 0;
		recv_idle = 1;
		set_window(36'h8_0000_0000, 36'h8_0001_0000);
		for (i = 0; i < 150; i++)
			do_alloc(1);
		for (i = 0; i < grant_page_q.size(); i += 2)
			do_release(grant_page_q[i], 1);
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		set_window(36'h0_0020_0000, 36'h0_0020_0400);
		hold_off_cycles = 600;
		repeat (30) do_alloc($urandom_range(1, 8));
		wait_drained();
		send_idle = 1;
		recv_idle = 1;
		repeat (30) begin
			if ($urandom_range(0, 1) && grant_page_q.size() > 0)
				release_random_grant();
			else
				do_alloc($urandom_range(1, 8));
		end
	endtask

	task automatic test_wide_fields(input int n);
		in_item_t it;
		out_item_t res;
		int r;
		send_idle = 1;
		recv_idle = 1;
		set_window(PAGE_W'({$urandom, $urandom} >> 2), PAGE_MASK);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				set_window(PAGE_W'({$urandom, $urandom}), PAGE_W'({$urandom, $urandom}));
			it.opcode = $urandom_range(0, 1) ? OP_RELEASE : OP_ALLOC;
			it.page_count = COUNT_W'($urandom);
			it.release_page = PAGE_W'({$urandom, $urandom});
			send_item(it, res);
		end
	endtask

	initial begin
		failures = 0;
		hold_off_cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_HEAP_FIRST;
		cfg_data = '0;
		heap_first = '0;
		heap_limit = LIMIT_RESET;
		bump_m = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hole_used_m[i] = 1'b0;
			hole_base_m[i] = '0;
			hole_len_m[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_churn(550);
		test_table_full();
		test_backpressure();
		test_wide_fields(150);
		wait_drained();
		repeat (50) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/prha_pkg.sv
src/prha_hole_ram.sv
src/page_range_hole_allocator_core.sv
bench/tb_page_range_hole_allocator_core.sv
